[rtl/csv_field_splitter_assert.svh]
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csf_pkg.sv]
package csf_pkg;

    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;

    localparam logic [7:0]  SEPARATOR_RESET    = 8'd44;
    localparam logic [10:0] COLUMN_COUNT_RESET = 11'd1;

    localparam logic CFG_SEPARATOR    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic [1:0] EV_CONTENT   = 2'd0;
    localparam logic [1:0] EV_FIELD_END = 2'd1;
    localparam logic [1:0] EV_ROW_END   = 2'd2;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          QAW         = 2;
    localparam logic [10:0] COL_OUT_MAX = 11'd1023;

    typedef struct packed {
        logic [7:0] data;
        logic       is_brk;
        logic       is_quote;
        logic       is_sep;
    } item_t;

    typedef enum logic [4:0] {
        MODE_START  = 5'b00001,
        MODE_PLAIN  = 5'b00010,
        MODE_QUOTED = 5'b00100,
        MODE_QSEEN  = 5'b01000,
        MODE_SKIP   = 5'b10000
    } mode_t;

endpackage

[rtl/csf_front.sv]
module csf_front (
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic [7:0]    separator,
    input  logic          q_full,
    output logic          q_push,
    output csf_pkg::item_t q_item
);
    import csf_pkg::*;

    logic brk;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign brk     = (s_in_byte == CH_CR) || (s_in_byte == CH_LF);

    always_comb begin
        q_item.data     = s_in_byte;
        q_item.is_brk   = brk;
        q_item.is_quote = (s_in_byte == CH_QUOTE);
        q_item.is_sep   = !brk && (s_in_byte == separator);
    end

endmodule

[rtl/csf_queue.sv]
module csf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  csf_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output csf_pkg::item_t head_item
);
    import csf_pkg::*;

    item_t          slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_pop;

    assign full       = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/csf_back.sv]
module csf_back #(
    parameter int MAX_COLUMNS     = 1024,
    parameter int MAX_FIELD_BYTES = 512
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [10:0]    column_count,
    input  logic           q_valid,
    input  csf_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_event_res,
    output logic [7:0]     m_out_byte,
    output logic [9:0]     m_column,
    output logic           m_field_empty
);
    import csf_pkg::*;
    `include "csv_field_splitter_assert.svh"

    localparam int CIW  = $clog2(MAX_COLUMNS + 1);
    localparam int FLW  = $clog2(MAX_FIELD_BYTES);
    localparam int CMPW = (CIW > 11) ? CIW : 11;
    localparam logic [CMPW-1:0] MAX_COL_C  = CMPW'(MAX_COLUMNS);
    localparam logic [FLW-1:0]  FL_LIMIT_C = FLW'(MAX_FIELD_BYTES - 1);

    mode_t          mode_reg, mode_next;
    logic [CIW-1:0] col_reg, col_next;
    logic [FLW-1:0] flen_reg, flen_next;
    logic           line_reg, line_next;

    logic       ovalid_reg, ovalid_next;
    logic [1:0] oevent_reg, oevent_next;
    logic [7:0] obyte_reg, obyte_next;
    logic [9:0] ocol_reg, ocol_next;
    logic       oempty_reg, oempty_next;

    logic [CMPW-1:0] kept;
    logic [CMPW-1:0] col_ext;
    logic            col_kept;
    logic            advance;
    logic            emit;
    logic [1:0]      ev;
    logic            ev_empty;
    logic            do_content;
    logic            do_field_end;

    always_comb begin
        kept = CMPW'(column_count);
        if (kept == '0) begin
            kept = CMPW'(1);
        end
        if (kept > MAX_COL_C) begin
            kept = MAX_COL_C;
        end
        if (kept > CMPW'(1024)) begin
            kept = CMPW'(1024);
        end
    end

    assign col_ext  = CMPW'(col_reg);
    assign col_kept = (col_ext < kept);
    assign advance  = !ovalid_reg || m_ready;
    assign q_pop    = q_valid && advance;

    always_comb begin
        mode_next    = mode_reg;
        col_next     = col_reg;
        flen_next    = flen_reg;
        line_next    = line_reg;
        emit         = 1'b0;
        ev           = EV_CONTENT;
        ev_empty     = 1'b0;
        do_content   = 1'b0;
        do_field_end = 1'b0;

        if (q_pop) begin
            if (q_item.is_brk) begin
                mode_next = MODE_START;
                if (line_reg) begin
                    emit      = 1'b1;
                    ev        = EV_ROW_END;
                    ev_empty  = col_kept ? (flen_reg == '0) : 1'b1;
                    col_next  = '0;
                    flen_next = '0;
                    line_next = 1'b0;
                end
            end else begin
                line_next = 1'b1;
                unique case (mode_reg)
                    MODE_START: begin
                        if (q_item.is_quote) begin
                            mode_next = MODE_QUOTED;
                        end else if (q_item.is_sep) begin
                            do_field_end = 1'b1;
                        end else begin
                            mode_next  = MODE_PLAIN;
                            do_content = 1'b1;
                        end
                    end
                    MODE_PLAIN: begin
                        if (q_item.is_sep) begin
                            do_field_end = 1'b1;
                        end else begin
                            do_content = 1'b1;
                        end
                    end
                    MODE_QUOTED: begin
                        if (q_item.is_quote) begin
                            mode_next = MODE_QSEEN;
                        end else begin
                            do_content = 1'b1;
                        end
                    end
                    MODE_QSEEN: begin
                        if (q_item.is_quote) begin
                            mode_next  = MODE_QUOTED;
                            do_content = 1'b1;
                        end else if (q_item.is_sep) begin
                            do_field_end = 1'b1;
                        end else begin
                            mode_next = MODE_SKIP;
                        end
                    end
                    MODE_SKIP: begin
                        if (q_item.is_sep) begin
                            do_field_end = 1'b1;
                        end
                    end
                    default: begin
                        mode_next = MODE_SKIP;
                    end
                endcase

                if (do_content && col_kept && (flen_reg < FL_LIMIT_C)) begin
                    flen_next = flen_reg + 1'b1;
                    emit      = 1'b1;
                    ev        = EV_CONTENT;
                end
                if (do_field_end) begin
                    emit     = col_kept;
                    ev       = EV_FIELD_END;
                    ev_empty = (flen_reg == '0);
                    if (col_ext < MAX_COL_C) begin
                        col_next = col_reg + 1'b1;
                    end
                    flen_next = '0;
                    mode_next = MODE_START;
                end
            end
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        oevent_next = oevent_reg;
        obyte_next  = obyte_reg;
        ocol_next   = ocol_reg;
        oempty_next = oempty_reg;
        if (advance) begin
            ovalid_next = emit;
            if (emit) begin
                oevent_next = ev;
                obyte_next  = (ev == EV_CONTENT) ? q_item.data : 8'd0;
                ocol_next   = (col_ext > CMPW'(COL_OUT_MAX)) ? 10'd1023 : col_ext[9:0];
                oempty_next = ev_empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_START;
            col_reg    <= '0;
            flen_reg   <= '0;
            line_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            col_reg    <= col_next;
            flen_reg   <= flen_next;
            line_reg   <= line_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        oevent_reg <= oevent_next;
        obyte_reg  <= obyte_next;
        ocol_reg   <= ocol_next;
        oempty_reg <= oempty_next;
    end

    assign m_valid       = ovalid_reg;
    assign m_event_res   = oevent_reg;
    assign m_out_byte    = obyte_reg;
    assign m_column      = ocol_reg;
    assign m_field_empty = oempty_reg;

    `CSF_ASSERT_NOW(a_flen_bound, aclk, aresetn, 1'b1, flen_reg <= FL_LIMIT_C,
        "field length past limit")
    `CSF_ASSERT_NOW(a_end_byte_zero, aclk, aresetn,
        ovalid_reg && (oevent_reg != EV_CONTENT), obyte_reg == 8'd0,
        "field end transaction carries a byte")
    `CSF_ASSERT_NEXT(a_brk_resets_row, aclk, aresetn, q_pop && q_item.is_brk,
        (col_reg == '0) && (flen_reg == '0) && !line_reg && (mode_reg == MODE_START),
        "line break left row state behind")
    `CSF_ASSERT_NEXT(a_row_end_clears_line, aclk, aresetn, emit && advance && (ev == EV_ROW_END),
        m_valid && (m_event_res == EV_ROW_END),
        "row end transaction lost")

endmodule

[rtl/csv_field_splitter.sv]
// CSV field splitter: takes CSV text one byte per clock while its queue is not full and
// emits one transaction per kept content byte, per field end in a kept column and per row
// end of a non-empty line, each tagged with its zero-based column. The sustained rate is
// one byte per clock, set by the parser state update in the back end, which advances one
// byte a cycle whenever its output register is free. A four-entry queue between the byte
// classifier and the parser absorbs stalls on the result side. Program separator (index 0)
// and column_count (index 1) only while no bytes are in flight. The text must end with LF
// or CR for the last row to close.
module csv_field_splitter #(
    parameter int MAX_COLUMNS     = 1024,
    parameter int MAX_FIELD_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [7:0]  m_out_byte,
    output logic [9:0]  m_column,
    output logic        m_field_empty
);
    import csf_pkg::*;

    logic [7:0]  separator_reg;
    logic [10:0] column_count_reg;

    logic  q_full;
    logic  q_push;
    item_t q_in_item;
    logic  q_pop;
    logic  q_head_valid;
    item_t q_head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg    <= SEPARATOR_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SEPARATOR:    separator_reg    <= cfg_wdata[7:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                default:          separator_reg    <= separator_reg;
            endcase
        end
    end

    csf_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .separator (separator_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    csf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_in_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    csf_back #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .column_count  (column_count_reg),
        .q_valid       (q_head_valid),
        .q_item        (q_head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_out_byte    (m_out_byte),
        .m_column      (m_column),
        .m_field_empty (m_field_empty)
    );

endmodule

[tb/sv/csv_field_splitter_tb.sv]
`timescale 1ns / 100ps

module csv_field_splitter_tb;
    import csf_pkg::*;

    localparam int MAX_COLUMNS     = 1024;
    localparam int MAX_FIELD_BYTES = 512;
    localparam int REG_HOLD_OFF    = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int STALL_LIMIT     = 400;
    localparam int DIR_STEPS       = 29;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
        logic [9:0] col;
        logic       is_empty;
    } split_ev_t;

    typedef struct packed {
        logic        is_cfg;
        logic        cfg_idx;
        logic [10:0] val;
        logic        typed;
        logic        has_res;
        split_ev_t   res;
    } dir_step_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        m_valid;
    logic        m_ready   = 1'b1;
    logic [1:0]  m_event_res;
    logic [7:0]  m_out_byte;
    logic [9:0]  m_column;
    logic        m_field_empty;

    csv_field_splitter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_out_byte    (m_out_byte),
        .m_column      (m_column),
        .m_field_empty (m_field_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // splitter state mirrored on the bench side
    logic [7:0]  sep_r   = SEPARATOR_RESET;
    logic [10:0] ncols_r = COLUMN_COUNT_RESET;
    mode_t       mode_r  = MODE_START;
    int unsigned col_idx = 0;
    int unsigned fld_len = 0;
    bit          line_open = 1'b0;

    split_ev_t pending_events[$];
    dir_step_t dir_tab [DIR_STEPS];

    bit calm = 1'b0;
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_rows = 0;
    int n_writes = 0;
    int rx_wait = 0;
    int wait_draw;
    int idle_cycles = 0;
    split_ev_t want;

    function automatic int unsigned kept_cols();
        int unsigned lim;
        lim = ncols_r;
        if (lim == 0) lim = 1;
        if (lim > MAX_COLUMNS) lim = MAX_COLUMNS;
        if (lim > 1024) lim = 1024;
        return lim;
    endfunction

    function automatic logic [9:0] col_tag();
        return (col_idx > 1023) ? 10'd1023 : col_idx[9:0];
    endfunction

    function automatic bit take_content(input logic [7:0] b, output split_ev_t r);
        r = '0;
        if (col_idx >= kept_cols() || fld_len >= MAX_FIELD_BYTES - 1) return 1'b0;
        fld_len++;
        r = '{EV_CONTENT, b, col_tag(), 1'b0};
        return 1'b1;
    endfunction

    function automatic bit close_field(output split_ev_t r);
        bit kept;
        r = '0;
        kept = col_idx < kept_cols();
        if (kept) r = '{EV_FIELD_END, 8'h00, col_tag(), fld_len == 0};
        if (col_idx < MAX_COLUMNS) col_idx++;
        fld_len = 0;
        mode_r = MODE_START;
        return kept;
    endfunction

    function automatic bit close_row(output split_ev_t r);
        r = '{EV_ROW_END, 8'h00, col_tag(), (col_idx < kept_cols()) ? (fld_len == 0) : 1'b1};
        col_idx = 0;
        fld_len = 0;
        mode_r = MODE_START;
        line_open = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit split_step(input logic [7:0] b, output split_ev_t r);
        r = '0;
        if (b == CH_CR || b == CH_LF) begin
            if (!line_open) begin
                mode_r = MODE_START;
                return 1'b0;
            end
            return close_row(r);
        end
        line_open = 1'b1;
        case (mode_r)
            MODE_START: begin
                if (b == CH_QUOTE) begin
                    mode_r = MODE_QUOTED;
                    return 1'b0;
                end
                if (b == sep_r) return close_field(r);
                mode_r = MODE_PLAIN;
                return take_content(b, r);
            end
            MODE_PLAIN: begin
                if (b == sep_r) return close_field(r);
                return take_content(b, r);
            end
            MODE_QUOTED: begin
                if (b == CH_QUOTE) begin
                    mode_r = MODE_QSEEN;
                    return 1'b0;
                end
                return take_content(b, r);
            end
            MODE_QSEEN: begin
                if (b == CH_QUOTE) begin
                    mode_r = MODE_QUOTED;
                    return take_content(b, r);
                end
                if (b == sep_r) return close_field(r);
                mode_r = MODE_SKIP;
                return 1'b0;
            end
            default: begin
                mode_r = MODE_SKIP;
                if (b == sep_r) return close_field(r);
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic dir_step_t plain_step(input logic [7:0] b);
        dir_step_t s;
        s = '0;
        s.val = {3'b000, b};
        return s;
    endfunction

    function automatic dir_step_t typed_step(input logic [7:0] b, input bit has,
                                             input logic [1:0] ev, input logic [7:0] data,
                                             input logic [9:0] col, input logic e);
        dir_step_t s;
        s = '0;
        s.val = {3'b000, b};
        s.typed = 1'b1;
        s.has_res = has;
        s.res = '{ev, data, col, e};
        return s;
    endfunction

    function automatic dir_step_t reg_step(input logic idx, input logic [10:0] v);
        dir_step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.cfg_idx = idx;
        s.val = v;
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input bit has_res,
                             input split_ev_t res);
        int gap;
        bit hit;
        split_ev_t pred;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hit = split_step(b, pred);
        if (typed) begin
            hit = has_res;
            pred = res;
        end
        if (hit) pending_events.push_back(pred);
        n_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_byte(b, 1'b0, 1'b0, '0);
    endtask

    // drain, let in-flight bytes settle, then program
    task automatic write_reg(input logic idx, input logic [10:0] data);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (REG_HOLD_OFF) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SEPARATOR) sep_r = data[7:0];
        else ncols_r = data;
        n_writes++;
    endtask

    function automatic logic [7:0] pick_byte(input bit allow_quote, input bit allow_sep);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF || (!allow_quote && b == CH_QUOTE) ||
               (!allow_sep && b == sep_r));
        return b;
    endfunction

    task automatic add_field();
        int r;
        int n;
        int k;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return;
        end else if (r < 55) begin
            put_byte(pick_byte(1'b0, 1'b0));
            n = $urandom_range(0, 7);
            repeat (n) put_byte(pick_byte(1'b1, 1'b0));
        end else if (r < 85) begin
            put_byte(CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                k = $urandom_range(0, 99);
                if (k < 12) begin
                    put_byte(CH_QUOTE);
                    put_byte(CH_QUOTE);
                end else if (k < 25) begin
                    put_byte(sep_r);
                end else if (k < 28) begin
                    put_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
                end else begin
                    put_byte(pick_byte(1'b0, 1'b1));
                end
            end
            put_byte(CH_QUOTE);
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) put_byte(pick_byte(1'b0, 1'b0));
            end
        end else if (r < 87) begin
            put_byte(pick_byte(1'b0, 1'b0));
            n = $urandom_range(20, 30);
            repeat (n) put_byte(pick_byte(1'b1, 1'b0));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_row(input bit wide);
        int nf;
        int r;
        if ($urandom_range(0, 9) == 0) put_byte(CH_LF);
        nf = wide ? 12 + $urandom_range(0, 8) : $urandom_range(1, 6);
        for (int i = 0; i < nf; i++) begin
            if (i > 0) put_byte(sep_r);
            if (wide) begin
                if ($urandom_range(0, 9) == 0) put_byte(pick_byte(1'b0, 1'b0));
            end else begin
                add_field();
            end
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            put_byte(CH_LF);
        end else if (r < 8) begin
            put_byte(CH_CR);
            put_byte(CH_LF);
        end else begin
            put_byte(CH_CR);
        end
    endtask

    task automatic check_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected transaction, got event %0d byte %0d column %0d",
                             $time, m_event_res, m_out_byte, m_column);
                    errors++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_res", want.ev, m_event_res);
                    check_field("out_byte", want.data, m_out_byte);
                    check_field("column", want.col, m_column);
                    check_field("field_empty", want.is_empty, m_field_empty);
                    n_checked++;
                    if (m_event_res == EV_ROW_END) n_rows++;
                end
                wait_draw = calm ? 0 : $urandom_range(0, 6);
                if (wait_draw > 0) begin
                    m_ready <= 1'b0;
                    rx_wait <= wait_draw;
                end
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                if (rx_wait == 1) m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int start;
        logic [7:0] sep_v;
        logic [10:0] cols_v;
        bit wide;

        dir_tab = '{
            typed_step("a", 1'b1, EV_CONTENT, "a", 10'd0, 1'b0),
            typed_step(",", 1'b1, EV_FIELD_END, 8'h00, 10'd0, 1'b0),
            typed_step("b", 1'b0, EV_CONTENT, 8'h00, 10'd0, 1'b0),
            typed_step(CH_LF, 1'b1, EV_ROW_END, 8'h00, 10'd1, 1'b1),
            typed_step(CH_LF, 1'b0, EV_CONTENT, 8'h00, 10'd0, 1'b0),
            typed_step(CH_CR, 1'b0, EV_CONTENT, 8'h00, 10'd0, 1'b0),
            reg_step(CFG_COLUMN_COUNT, 11'd4),
            plain_step(CH_QUOTE),
            plain_step("x"),
            plain_step(","),
            plain_step(CH_QUOTE),
            plain_step(CH_QUOTE),
            plain_step(CH_QUOTE),
            plain_step("z"),
            plain_step(","),
            plain_step(","),
            typed_step(8'hFF, 1'b1, EV_CONTENT, 8'hFF, 10'd2, 1'b0),
            typed_step(8'h00, 1'b1, EV_CONTENT, 8'h00, 10'd2, 1'b0),
            plain_step(CH_CR),
            plain_step(CH_LF),
            reg_step(CFG_SEPARATOR, 11'(CH_QUOTE)),
            plain_step("a"),
            plain_step(CH_QUOTE),
            plain_step("b"),
            plain_step(CH_LF),
            reg_step(CFG_SEPARATOR, 11'(CH_LF)),
            reg_step(CFG_COLUMN_COUNT, 11'd0),
            plain_step("q"),
            plain_step(CH_LF)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                write_reg(dir_tab[i].cfg_idx, dir_tab[i].val);
            end else begin
                send_byte(dir_tab[i].val[7:0], dir_tab[i].typed, dir_tab[i].has_res,
                          dir_tab[i].res);
            end
        end

        for (int p = 0; p < 8; p++) begin
            calm = (p % 3 == 2);
            wide = 1'b0;
            case (p)
                0: begin sep_v = 8'd44;                   cols_v = 11'd3;    end
                1: begin sep_v = 8'd59;                   cols_v = 11'd1;    end
                2: begin sep_v = 8'($urandom_range(0, 255)); cols_v = 11'($urandom_range(1, 8)); end
                3: begin sep_v = 8'h09;                   cols_v = 11'd2047; end
                4: begin sep_v = CH_QUOTE;                cols_v = 11'd0;    end
                5: begin sep_v = CH_CR;                   cols_v = 11'd5;    end
                6: begin sep_v = 8'hFF; cols_v = 11'd3; wide = 1'b1;         end
                default: begin sep_v = 8'h00; cols_v = 11'($urandom_range(1, 8)); end
            endcase
            write_reg(CFG_SEPARATOR, {3'($urandom_range(0, 7)), sep_v});
            write_reg(CFG_COLUMN_COUNT, cols_v);
            start = n_sent;
            if (wide) add_row(1'b1);
            while (n_sent - start < 60) add_row(1'b0);
        end

        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Fed %0d text bytes across %0d register writes (directed table, 8 random phases).",
                 n_sent, n_writes);
        $display("Checked %0d field transactions, %0d of them row ends; %0d mismatches.",
                 n_checked, n_rows, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[csv_field_splitter.f]
+incdir+rtl
rtl/csf_pkg.sv
rtl/csf_front.sv
rtl/csf_queue.sv
rtl/csf_back.sv
rtl/csv_field_splitter.sv
tb/sv/csv_field_splitter_tb.sv
